// ----- design/dbd_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dbd_pkg: shared types and constants for the days-between-dates core
// Item layouts for both channels, field widths, the year limit, the
// reciprocal used to divide by 100, and the days-before-month table.
// ---------------------------------------------------------------------------
package dbd_pkg;

	// Field widths
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned COUNT_W = 22;

	// Largest year taken as given; later years clamp to it
	localparam int unsigned MAX_YEAR = 9999;

	// Divide by 100 as (v * RECIP_100) >> RECIP_SH, exact for v < 2**YEAR_W
	localparam int unsigned RECIP_100 = 5243;
	localparam int unsigned RECIP_SH  = 19;
	localparam int unsigned RECIP_W   = 13;
	localparam int unsigned PROD_W    = YEAR_W + RECIP_W;
	localparam int unsigned QUOT_W    = 8;

	// Day-of-year offset of a month start (common year)
	localparam int unsigned DOY_W = 9;
	// Month part of a day number: offset + leap day + day field
	localparam int unsigned MDAY_W = 10;

	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

	// Start/end date pair
	typedef struct packed {
		logic [YEAR_W-1:0]  from_year;
		logic [MONTH_W-1:0] from_month;
		logic [DAY_W-1:0]   from_day;
		logic [YEAR_W-1:0]  to_year;
		logic [MONTH_W-1:0] to_month;
		logic [DAY_W-1:0]   to_day;
	} src_item_t;

	// Day count and order flag
	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic               order_error;
	} dst_item_t;

	// Days in the whole months before month m (m in 1..12)
	function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] d;
		unique case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// Quotient of a year-wide value by 100
	function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W-1:0] v);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(v) * PROD_W'(RECIP_100);
		return prod[RECIP_SH +: QUOT_W];
	endfunction

endpackage : dbd_pkg
`default_nettype wire

// ----- design/days_between_dates_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// days_between_dates_core: day count between two Gregorian dates
// Each date becomes a day number (whole years with the 4/100/400 rule,
// whole months, day of month); the result is end minus start, or zero with
// order_error set when the start date is later.
// ---------------------------------------------------------------------------
//
//  channel  signals                       item
//  -------  ----------------------------  ---------------------------------
//  src      src_valid, src_stall, src_item  start and end year/month/day
//  dst      dst_valid, dst_stall, dst_item  day_count, order_error
//
//  One item per cycle when dst is not stalled; five register stages, the
//  last being the output register that drives dst_valid and dst_item.
//  Stages: clamp, divide by 100 (reciprocal multiply), year and month
//  parts, day number sum, compare and subtract into the output register.
//  A stall on dst while dst_valid is high freezes every stage together and raises src_stall.
//  arst_n clears all stage valid bits; data registers are not reset.
//
module days_between_dates_core
	import dbd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,

	input  wire logic      src_valid,
	output logic           src_stall,
	input  wire src_item_t src_item,

	output logic           dst_valid,
	input  wire logic      dst_stall,
	output dst_item_t      dst_item
);

	// Lane 0 is the start date, lane 1 the end date
	localparam int unsigned LANES = 2;

	logic adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// Stage 1: clamped year and month, unclamped day, and year minus one
	logic [LANES-1:0][YEAR_W-1:0]  y_s1, p_s1;
	logic [LANES-1:0][MONTH_W-1:0] m_s1;
	logic [LANES-1:0][DAY_W-1:0]   d_s1;

	// Stage 2: quotients by 100 and 400
	logic [LANES-1:0][YEAR_W-1:0]  y_s2, p_s2;
	logic [LANES-1:0][MONTH_W-1:0] m_s2;
	logic [LANES-1:0][DAY_W-1:0]   d_s2;
	logic [LANES-1:0][QUOT_W-1:0]  py100_s2, py400_s2, y100_s2;

	// Stage 3: year part and month part of each day number
	logic [LANES-1:0][COUNT_W-1:0] yd_s3;
	logic [LANES-1:0][MDAY_W-1:0]  md_s3;

	// Stage 4: day numbers
	logic [LANES-1:0][COUNT_W-1:0] n_s4;

	logic [LANES-1:0][YEAR_W-1:0]  yr_in, y_cl, y_m1;
	logic [LANES-1:0][MONTH_W-1:0] mo_in, m_cl;
	logic [LANES-1:0][DAY_W-1:0]   dy_in;
	logic [LANES-1:0]              leap;
	logic [LANES-1:0][COUNT_W-1:0] yd_nxt;
	logic [LANES-1:0][MDAY_W-1:0]  md_nxt;

	dst_item_t res;

	// Whole pipeline moves unless a finished item is held on dst
	assign adv       = !(dst_valid && dst_stall);
	assign src_stall = !adv;

	// Lane inputs
	assign yr_in[0] = src_item.from_year;
	assign mo_in[0] = src_item.from_month;
	assign dy_in[0] = src_item.from_day;
	assign yr_in[1] = src_item.to_year;
	assign mo_in[1] = src_item.to_month;
	assign dy_in[1] = src_item.to_day;

	// Clamp year and month into range
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			y_cl[k] = yr_in[k];
			if (y_cl[k] == '0) begin
				y_cl[k] = YEAR_W'(1);
			end
			if (32'(y_cl[k]) > MAX_YEAR) begin
				y_cl[k] = YEAR_W'(MAX_YEAR);
			end
			y_m1[k] = y_cl[k] - YEAR_W'(1);
			m_cl[k] = mo_in[k];
			if (m_cl[k] == '0) begin
				m_cl[k] = MONTH_JAN;
			end
			if (m_cl[k] > MONTH_DEC) begin
				m_cl[k] = MONTH_DEC;
			end
		end
	end

	// Leap test, year part and month part
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			leap[k] = (y_s2[k][1:0] == 2'b00) &&
				((y_s2[k] != YEAR_W'(y100_s2[k]) * YEAR_W'(100)) ||
				 (y100_s2[k][1:0] == 2'b00));
			yd_nxt[k] = COUNT_W'(p_s2[k]) * COUNT_W'(365)
				+ COUNT_W'(p_s2[k][YEAR_W-1:2])
				- COUNT_W'(py100_s2[k])
				+ COUNT_W'(py400_s2[k]);
			md_nxt[k] = MDAY_W'(days_before_month(m_s2[k]))
				+ MDAY_W'(leap[k] && (m_s2[k] > MONTH_FEB))
				+ MDAY_W'(d_s2[k]);
		end
	end

	// Order check and count
	always_comb begin
		if (n_s4[0] > n_s4[1]) begin
			res.day_count   = '0;
			res.order_error = 1'b1;
		end else begin
			res.day_count   = n_s4[1] - n_s4[0];
			res.order_error = 1'b0;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			dst_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= src_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			dst_valid <= vld_s4;
		end
	end

	// Stage data
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++) begin
				y_s1[k]     <= y_cl[k];
				p_s1[k]     <= y_m1[k];
				m_s1[k]     <= m_cl[k];
				d_s1[k]     <= dy_in[k];

				y_s2[k]     <= y_s1[k];
				p_s2[k]     <= p_s1[k];
				m_s2[k]     <= m_s1[k];
				d_s2[k]     <= d_s1[k];
				py100_s2[k] <= div100(p_s1[k]);
				py400_s2[k] <= div100(YEAR_W'(p_s1[k][YEAR_W-1:2]));
				y100_s2[k]  <= div100(y_s1[k]);

				yd_s3[k]    <= yd_nxt[k];
				md_s3[k]    <= md_nxt[k];

				n_s4[k]     <= yd_s3[k] + COUNT_W'(md_s3[k]);
			end
			dst_item <= res;
		end
	end

`ifndef SYNTHESIS
	// An order error always comes with a zero count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.order_error |-> dst_item.day_count == '0)
		else $error("order_error with nonzero day_count");

	// A held output freezes every stage
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> $stable({vld_s1, vld_s2, vld_s3, vld_s4}))
		else $error("pipeline moved during a stall");

	// Leap years are multiples of four
	a_leap4: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && (leap[0] || leap[1]) |->
		(!leap[0] || y_s2[0][1:0] == 2'b00) && (!leap[1] || y_s2[1][1:0] == 2'b00))
		else $error("leap flag on a year not divisible by four");
`endif

endmodule : days_between_dates_core
`default_nettype wire
